[rtl/core/daif_pkg.sv]
package daif_pkg;

  // configuration port
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_index_t;

  // frame size limits and reset values
  localparam int MIN_SIZE     = 3;
  localparam int WIDTH_RESET  = 2048;
  localparam int HEIGHT_RESET = 2048;

  // pixel layout: red in the low bits, then green, then blue
  localparam int NUM_CHANNELS = 3;

  // results released by one transaction, and the result queue behind them
  localparam int MAX_RESULTS = 4;
  localparam int QUEUE_DEPTH = 8;

  // line store row slot, row number modulo three
  typedef logic [1:0] slot_t;
  localparam slot_t SLOT_FIRST = 2'd0;
  localparam slot_t SLOT_LAST  = 2'd2;

  function automatic slot_t slot_next(input slot_t s);
    slot_t n;
    n = (s == SLOT_LAST) ? SLOT_FIRST : slot_t'(s + 2'd1);
    return n;
  endfunction

  function automatic slot_t slot_prev(input slot_t s);
    slot_t p;
    p = (s == SLOT_FIRST) ? SLOT_LAST : slot_t'(s - 2'd1);
    return p;
  endfunction

endpackage

[rtl/core/daif_if.sv]
// raster pixel channel
interface daif_pix_if #(
  parameter int CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red_in;
  logic [CHANNEL_BITS-1:0] green_in;
  logic [CHANNEL_BITS-1:0] blue_in;

  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

// filtered pixel channel with coordinates
interface daif_res_if #(
  parameter int CHANNEL_BITS = 8,
  parameter int COLUMN_BITS  = 11,
  parameter int ROW_BITS     = 12
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red_out;
  logic [CHANNEL_BITS-1:0] green_out;
  logic [CHANNEL_BITS-1:0] blue_out;
  logic [COLUMN_BITS-1:0]  out_column;
  logic [ROW_BITS-1:0]     out_row;
  logic                    last_of_run;
  logic                    end_of_frame;

  modport source (
    output valid, red_out, green_out, blue_out, out_column, out_row, last_of_run,
           end_of_frame,
    input  ready
  );
  modport sink (
    input  valid, red_out, green_out, blue_out, out_column, out_row, last_of_run,
           end_of_frame,
    output ready
  );
endinterface

[rtl/core/daif_cfg_regs.sv]
module daif_cfg_regs #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [daif_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [daif_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [daif_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                 pready,
  output logic [$clog2(MAX_WIDTH+1)-1:0]       image_width,
  output logic [$clog2(MAX_HEIGHT+1)-1:0]      image_height
);
  import daif_pkg::*;

  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int HB = $clog2(MAX_HEIGHT + 1);

  localparam logic [WB-1:0] W_MIN = WB'(MIN_SIZE);
  localparam logic [WB-1:0] W_MAX = WB'(MAX_WIDTH);
  localparam logic [WB-1:0] W_RST = WB'((WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET);
  localparam logic [HB-1:0] H_MIN = HB'(MIN_SIZE);
  localparam logic [HB-1:0] H_MAX = HB'(MAX_HEIGHT);
  localparam logic [HB-1:0] H_RST =
    HB'((HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET);

  logic [WB-1:0] width_r, width_nxt, wdata_w;
  logic [HB-1:0] height_r, height_nxt, wdata_h;
  logic          wr_en;
  reg_index_t    reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = reg_index_t'(paddr[APB_ADDR_BITS-1]);
  assign wdata_w = pwdata[WB-1:0];
  assign wdata_h = pwdata[HB-1:0];

  // clamp written sizes into the supported range
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_IMAGE_WIDTH: begin
          width_nxt = (wdata_w < W_MIN) ? W_MIN : ((wdata_w > W_MAX) ? W_MAX : wdata_w);
        end
        REG_IMAGE_HEIGHT: begin
          height_nxt = (wdata_h < H_MIN) ? H_MIN : ((wdata_h > H_MAX) ? H_MAX : wdata_h);
        end
        default: begin
          width_nxt = width_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= W_RST;
      height_r <= H_RST;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // read back
  always_comb begin
    unique case (reg_sel)
      REG_IMAGE_WIDTH:  prdata = APB_DATA_BITS'(width_r);
      REG_IMAGE_HEIGHT: prdata = APB_DATA_BITS'(height_r);
      default:          prdata = '0;
    endcase
  end

  assign image_width  = width_r;
  assign image_height = height_r;

endmodule

[rtl/core/daif_line_store.sv]
module daif_line_store #(
  parameter int COLUMN_BITS = 11,
  parameter int DATA_BITS   = 24
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  daif_pkg::slot_t        wr_slot,
  input  logic [COLUMN_BITS-1:0] wr_col,
  input  logic [DATA_BITS-1:0]   wr_data,
  input  logic                   rd_en,
  input  daif_pkg::slot_t        rd_slot_a,
  input  daif_pkg::slot_t        rd_slot_b,
  input  logic [COLUMN_BITS-1:0] rd_col,
  output logic [DATA_BITS-1:0]   rd_data_a_r,
  output logic [DATA_BITS-1:0]   rd_data_b_r
);
  import daif_pkg::*;

  // three row slots, each a power-of-two span of columns
  localparam int DEPTH = 3 << COLUMN_BITS;

  logic [DATA_BITS-1:0] mem [DEPTH];

  // one write port, two read ports, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{wr_slot, wr_col}] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a_r <= mem[{rd_slot_a, rd_col}];
      rd_data_b_r <= mem[{rd_slot_b, rd_col}];
    end
  end

endmodule

[rtl/core/diagonal_average_image_filter.sv]
// A pixel is registered in stage one, then its results are queued. Throughput: one pixel per
// cycle; a pixel in the last column or last row, outside the first row and column, releases
// two to four results, which leave one per cycle through the eight-entry result queue while
// the output is ready, so input is held off while the queue lacks room for four more.
// Reset: raster position to row 0 column 0, size registers to 2048 by 2048; the line
// store is not cleared.
module diagonal_average_image_filter #(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_HEIGHT   = 4096,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  daif_pix_if.sink                           in_ch,
  daif_res_if.source                         out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [daif_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [daif_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [daif_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready
);
  import daif_pkg::*;

  localparam int CB  = $clog2(MAX_WIDTH);
  localparam int WB  = $clog2(MAX_WIDTH + 1);
  localparam int RB  = $clog2(MAX_HEIGHT);
  localparam int HB  = $clog2(MAX_HEIGHT + 1);
  localparam int PB  = NUM_CHANNELS * CHANNEL_BITS;
  localparam int SB  = CHANNEL_BITS + 2;
  localparam int QB  = $clog2(QUEUE_DEPTH);
  localparam int QCB = $clog2(QUEUE_DEPTH + 1);
  localparam int NB  = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic          has_res;
    logic          interior;
    logic          last_col;
    logic          last_row;
  } pos_flags_t;

  typedef struct packed {
    logic [PB-1:0] pix;
    logic [CB-1:0] col;
    logic [RB-1:0] row;
    logic          last;
    logic          eof;
  } entry_t;

  logic [WB-1:0] image_width;
  logic [HB-1:0] image_height;

  // configuration registers
  daif_cfg_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .image_width  (image_width),
    .image_height (image_height)
  );

  // raster position
  logic [CB-1:0] col_r, col_nxt, cur_col;
  logic [RB-1:0] row_r, row_nxt, cur_row;
  slot_t         slot_r, slot_nxt, cur_slot;
  logic [WB-1:0] col_inc;
  logic [HB-1:0] row_adv, row_inc;
  logic          col_wrap, row_over;
  pos_flags_t    cur_flags;
  logic [NB-1:0] cur_nres;
  logic [PB-1:0] in_pix;
  logic          accept;

  // stage one
  logic          s1_valid_r;
  logic [PB-1:0] s1_pix_r;
  logic [CB-1:0] s1_col_r;
  logic [RB-1:0] s1_row_r;
  pos_flags_t    s1_flags_r;
  logic [NB-1:0] s1_nres_r;

  // line store read data and neighbour window
  logic [PB-1:0] rd_up, rd_mid;
  logic [PB-1:0] win_up1_r, win_up2_r, win_lo1_r, win_lo2_r, win_mid1_r;
  logic [PB-1:0] mean_pix;

  // result queue
  entry_t         q_entry_r [QUEUE_DEPTH];
  logic [QB-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCB-1:0] count_r;
  logic [NB-1:0]  push_n;
  logic           pop;
  entry_t         res [MAX_RESULTS];
  logic           res_en [MAX_RESULTS];
  logic [QB-1:0]  res_pos [MAX_RESULTS];
  entry_t         head;

  assign in_pix = {in_ch.blue_in, in_ch.green_in, in_ch.red_in};

  // room for the stage one results and a worst-case new transaction
  assign in_ch.ready = ((QCB+1)'(count_r) + (QCB+1)'(s1_nres_r))
                       <= (QCB+1)'(QUEUE_DEPTH - MAX_RESULTS);
  assign accept = in_ch.valid & in_ch.ready;

  // position of this transaction, moved on if the size shrank under it
  always_comb begin
    col_wrap = WB'(col_r) >= image_width;
    row_adv  = HB'(row_r) + HB'(col_wrap);
    row_over = row_adv >= image_height;
    cur_col  = col_wrap ? '0 : col_r;
    cur_row  = row_over ? '0 : row_adv[RB-1:0];
    priority if (row_over) begin
      cur_slot = SLOT_FIRST;
    end else if (col_wrap) begin
      cur_slot = slot_next(slot_r);
    end else begin
      cur_slot = slot_r;
    end

    cur_flags.last_col = WB'(cur_col) == (image_width - WB'(1));
    cur_flags.last_row = HB'(cur_row) == (image_height - HB'(1));
    cur_flags.has_res  = (cur_col != '0) && (cur_row != '0);
    cur_flags.interior = (cur_col > CB'(1)) && (cur_row > RB'(1));
    cur_nres = cur_flags.has_res ?
               (NB'(1) + NB'(cur_flags.last_col) + NB'(cur_flags.last_row)
                + NB'(cur_flags.last_col & cur_flags.last_row)) : '0;
  end

  // next raster position
  always_comb begin
    col_inc = WB'(cur_col) + WB'(1);
    row_inc = HB'(cur_row) + HB'(1);
    if (col_inc == image_width) begin
      col_nxt = '0;
      if (row_inc == image_height) begin
        row_nxt  = '0;
        slot_nxt = SLOT_FIRST;
      end else begin
        row_nxt  = row_inc[RB-1:0];
        slot_nxt = slot_next(cur_slot);
      end
    end else begin
      col_nxt  = col_inc[CB-1:0];
      row_nxt  = cur_row;
      slot_nxt = cur_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      slot_r     <= SLOT_FIRST;
      s1_valid_r <= 1'b0;
      s1_nres_r  <= '0;
    end else begin
      s1_valid_r <= accept;
      s1_nres_r  <= accept ? cur_nres : '0;
      if (accept) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        slot_r <= slot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r   <= in_pix;
      s1_col_r   <= cur_col;
      s1_row_r   <= cur_row;
      s1_flags_r <= cur_flags;
    end
  end

  // line store: write this row, read the two rows above at the same column
  daif_line_store #(
    .COLUMN_BITS (CB),
    .DATA_BITS   (PB)
  ) u_store (
    .clk         (clk),
    .wr_en       (accept),
    .wr_slot     (cur_slot),
    .wr_col      (cur_col),
    .wr_data     (in_pix),
    .rd_en       (accept),
    .rd_slot_a   (slot_next(cur_slot)),
    .rd_slot_b   (slot_prev(cur_slot)),
    .rd_col      (cur_col),
    .rd_data_a_r (rd_up),
    .rd_data_b_r (rd_mid)
  );

  // neighbour window shifts once per transaction
  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      win_up2_r  <= win_up1_r;
      win_up1_r  <= rd_up;
      win_lo2_r  <= win_lo1_r;
      win_lo1_r  <= s1_pix_r;
      win_mid1_r <= rd_mid;
    end
  end

  // mean of the four diagonal neighbours, per channel
  always_comb begin
    logic [SB-1:0] sum;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      sum = SB'(win_up2_r[k*CHANNEL_BITS +: CHANNEL_BITS])
          + SB'(rd_up[k*CHANNEL_BITS +: CHANNEL_BITS])
          + SB'(win_lo2_r[k*CHANNEL_BITS +: CHANNEL_BITS])
          + SB'(s1_pix_r[k*CHANNEL_BITS +: CHANNEL_BITS]);
      mean_pix[k*CHANNEL_BITS +: CHANNEL_BITS] = sum[SB-1:2];
    end
  end

  // results released by the stage one transaction, in output order
  always_comb begin
    res[0].pix  = s1_flags_r.interior ? mean_pix : win_mid1_r;
    res[0].col  = s1_col_r - CB'(1);
    res[0].row  = s1_row_r - RB'(1);
    res[0].last = s1_nres_r == NB'(1);
    res[0].eof  = 1'b0;
    res_en[0]   = s1_flags_r.has_res;
    res_pos[0]  = QB'(0);

    // right border pixel of the row above
    res[1].pix  = rd_mid;
    res[1].col  = s1_col_r;
    res[1].row  = s1_row_r - RB'(1);
    res[1].last = ~s1_flags_r.last_row;
    res[1].eof  = 1'b0;
    res_en[1]   = s1_flags_r.has_res & s1_flags_r.last_col;
    res_pos[1]  = QB'(1);

    // bottom border pixel to the left
    res[2].pix  = win_lo1_r;
    res[2].col  = s1_col_r - CB'(1);
    res[2].row  = s1_row_r;
    res[2].last = ~s1_flags_r.last_col;
    res[2].eof  = 1'b0;
    res_en[2]   = s1_flags_r.has_res & s1_flags_r.last_row;
    res_pos[2]  = QB'(1) + QB'(s1_flags_r.last_col);

    // bottom right corner closes the frame
    res[3].pix  = s1_pix_r;
    res[3].col  = s1_col_r;
    res[3].row  = s1_row_r;
    res[3].last = 1'b1;
    res[3].eof  = 1'b1;
    res_en[3]   = s1_flags_r.has_res & s1_flags_r.last_col & s1_flags_r.last_row;
    res_pos[3]  = QB'(3);
  end

  // result queue
  assign push_n = s1_valid_r ? s1_nres_r : '0;
  assign pop    = out_ch.valid & out_ch.ready;

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
        if (res_en[k]) begin
          q_entry_r[wr_ptr_r + res_pos[k]] <= res[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QB'(push_n);
      rd_ptr_r <= rd_ptr_r + QB'(pop);
      count_r  <= count_r + QCB'(push_n) - QCB'(pop);
    end
  end

  // output side
  assign head                = q_entry_r[rd_ptr_r];
  assign out_ch.valid        = count_r != '0;
  assign out_ch.red_out      = head.pix[0 +: CHANNEL_BITS];
  assign out_ch.green_out    = head.pix[CHANNEL_BITS +: CHANNEL_BITS];
  assign out_ch.blue_out     = head.pix[2*CHANNEL_BITS +: CHANNEL_BITS];
  assign out_ch.out_column   = head.col;
  assign out_ch.out_row      = head.row;
  assign out_ch.last_of_run  = head.last;
  assign out_ch.end_of_frame = head.eof;

  // queue never overruns when stage one results land
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> ((QCB+1)'(count_r) + (QCB+1)'(s1_nres_r) <= (QCB+1)'(QUEUE_DEPTH)))
    else $error("result queue overrun");

  // the frame's final pixel always closes its run
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.end_of_frame) |-> out_ch.last_of_run)
    else $error("end of frame without last of run");

  // result coordinates lie inside the frame
  a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((WB'(out_ch.out_column) < image_width)
                      && (HB'(out_ch.out_row) < image_height)))
    else $error("result coordinate outside frame");

endmodule

[verif/tb_diagonal_average_image_filter.sv]
`timescale 1ns / 100ps

module tb_diagonal_average_image_filter;
  import daif_pkg::*;

  localparam int MAX_WIDTH     = 2048;
  localparam int MAX_HEIGHT    = 4096;
  localparam int CHANNEL_BITS  = 8;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_STALL    = 400;
  localparam int CYCLE_LIMIT   = 600000;

  typedef struct {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [10:0] column;
    logic [11:0] row;
    logic        last;
    logic        eof;
  } filtered_px_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic pready;

  daif_pix_if #(.CHANNEL_BITS(CHANNEL_BITS)) pix_ch ();
  daif_res_if #(.CHANNEL_BITS(CHANNEL_BITS)) res_ch ();

  diagonal_average_image_filter #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (pix_ch),
    .out_ch  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // filter state as seen by the predictor
  bit [23:0]    line_rows [3*MAX_WIDTH];
  bit [23:0]    corner_win [6];
  int unsigned  raster_col;
  int unsigned  raster_row;
  int unsigned  img_width;
  int unsigned  img_height;
  filtered_px_t expected_pixels [$];

  int          bad_count;
  int          cycle_count;
  int          send_gap_pct;
  int          recv_gap_pct;
  int          stall_request;
  int          stall_left;

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_bad(input string msg);
    bad_count++;
    if (bad_count <= 10) $display("%s", msg);
  endtask

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
    return (v < MIN_SIZE) ? MIN_SIZE : ((v > hi) ? hi : v);
  endfunction

  function automatic filtered_px_t filtered_px(input bit [23:0] v, input int unsigned c,
                                               input int unsigned r);
    filtered_px_t p;
    p.red    = v[7:0];
    p.green  = v[15:8];
    p.blue   = v[23:16];
    p.column = c[10:0];
    p.row    = r[11:0];
    p.last   = 1'b0;
    p.eof    = 1'b0;
    return p;
  endfunction

  // raster step: store the pixel, release whatever its neighbours now allow
  task automatic predict_pixel(input bit [23:0] pix);
    int unsigned  c;
    int unsigned  r;
    int unsigned  cur;
    int unsigned  prv;
    int unsigned  old;
    bit [23:0]    v;
    bit [9:0]     sum;
    filtered_px_t run [4];
    int           n;
    if (raster_col >= img_width) begin
      raster_col = 0;
      raster_row++;
    end
    if (raster_row >= img_height) raster_row = 0;
    c   = raster_col;
    r   = raster_row;
    cur = (r % 3) * MAX_WIDTH;
    prv = ((r + 2) % 3) * MAX_WIDTH;
    old = ((r + 1) % 3) * MAX_WIDTH;
    n   = 0;

    corner_win[0] = corner_win[1];
    corner_win[1] = corner_win[2];
    corner_win[2] = line_rows[old + c];
    corner_win[3] = corner_win[4];
    corner_win[4] = corner_win[5];
    corner_win[5] = pix;
    line_rows[cur + c] = pix;

    if (r >= 1 && c >= 1) begin
      if (c >= 2 && r >= 2) begin
        for (int k = 0; k < 3; k++) begin
          sum = corner_win[0][8*k +: 8] + corner_win[2][8*k +: 8]
              + corner_win[3][8*k +: 8] + corner_win[5][8*k +: 8];
          v[8*k +: 8] = sum[9:2];
        end
      end else begin
        v = line_rows[prv + c - 1];
      end
      run[n] = filtered_px(v, c - 1, r - 1);
      n++;
      if (c == img_width - 1) begin
        run[n] = filtered_px(line_rows[prv + c], c, r - 1);
        n++;
      end
      if (r == img_height - 1) begin
        run[n] = filtered_px(line_rows[cur + c - 1], c - 1, r);
        n++;
        if (c == img_width - 1) begin
          run[n] = filtered_px(pix, c, r);
          run[n].eof = 1'b1;
          n++;
        end
      end
      run[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_pixels.push_back(run[i]);
    end

    raster_col = c + 1;
    if (raster_col == img_width) begin
      raster_col = 0;
      raster_row = r + 1;
      if (raster_row == img_height) raster_row = 0;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    filtered_px_t exp_px;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (expected_pixels.size() == 0) begin
        report_bad($sformatf("unexpected result at col %0d row %0d",
                             res_ch.out_column, res_ch.out_row));
      end else begin
        exp_px = expected_pixels.pop_front();
        if (res_ch.red_out !== exp_px.red || res_ch.green_out !== exp_px.green ||
            res_ch.blue_out !== exp_px.blue || res_ch.out_column !== exp_px.column ||
            res_ch.out_row !== exp_px.row || res_ch.last_of_run !== exp_px.last ||
            res_ch.end_of_frame !== exp_px.eof) begin
          report_bad($sformatf({"mismatch exp rgb %0d %0d %0d col %0d row %0d",
                                " last %0b eof %0b | got rgb %0d %0d %0d",
                                " col %0d row %0d last %0b eof %0b"},
            exp_px.red, exp_px.green, exp_px.blue, exp_px.column, exp_px.row, exp_px.last,
            exp_px.eof, res_ch.red_out, res_ch.green_out, res_ch.blue_out,
            res_ch.out_column, res_ch.out_row, res_ch.last_of_run, res_ch.end_of_frame));
        end
      end
    end
  end

  // result side ready, with random gaps and an occasional long hold-off
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request != 0) begin
        stall_left = stall_request;
        stall_request <= 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_gap_pct = send_pct;
    recv_gap_pct <= recv_pct;
  endtask

  // offer one pixel and wait for its transaction
  task automatic send_pixel(input bit [23:0] pix);
    while ($urandom_range(99) < send_gap_pct) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid    <= 1'b1;
    pix_ch.red_in   <= pix[7:0];
    pix_ch.green_in <= pix[15:8];
    pix_ch.blue_in  <= pix[23:16];
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    predict_pixel(pix);
  endtask

  // channel values biased towards the extremes
  function automatic bit [23:0] random_pixel();
    bit [23:0] p;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(7))
        0: p[8*k +: 8] = 8'd0;
        1: p[8*k +: 8] = 8'd255;
        default: p[8*k +: 8] = 8'($urandom_range(255));
      endcase
    end
    return p;
  endfunction

  task automatic send_random_pixels(input int count);
    repeat (count) send_pixel(random_pixel());
  endtask

  // stop offering, wait for every pending result, then let the block go quiet
  task automatic settle();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_size_reg(input reg_index_t idx);
    int unsigned want;
    want = (idx == REG_IMAGE_WIDTH) ? img_width : img_height;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== APB_DATA_BITS'(want))
      report_bad($sformatf("register %s read %0d, expected %0d", idx.name(), prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_size(input reg_index_t idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) img_width = clamp_size(value & 32'hFFF, MAX_WIDTH);
    else img_height = clamp_size(value & 32'h1FFF, MAX_HEIGHT);
    @(posedge clk);
    check_size_reg(idx);
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h);
    settle();
    write_size(REG_IMAGE_WIDTH, w);
    write_size(REG_IMAGE_HEIGHT, h);
  endtask

  // reset values, then clamping at both ends of each size register
  task automatic test_size_registers();
    check_size_reg(REG_IMAGE_WIDTH);
    check_size_reg(REG_IMAGE_HEIGHT);
    write_size(REG_IMAGE_WIDTH, 0);
    write_size(REG_IMAGE_WIDTH, 2);
    write_size(REG_IMAGE_WIDTH, 12'hFFF);
    write_size(REG_IMAGE_WIDTH, MAX_WIDTH);
    write_size(REG_IMAGE_WIDTH, MIN_SIZE);
    write_size(REG_IMAGE_HEIGHT, 0);
    write_size(REG_IMAGE_HEIGHT, 13'h1FFF);
    write_size(REG_IMAGE_HEIGHT, MAX_HEIGHT);
    write_size(REG_IMAGE_HEIGHT, MIN_SIZE);
  endtask

  // smallest frame: one interior pixel, full-scale and truncating corner sums
  task automatic test_corner_mean();
    bit [23:0] px [9] = '{24'h0100FF, 24'h5A3CC3, 24'h0200FF,
                          24'hFF00FF, 24'h123456, 24'h00FF00,
                          24'h0000FF, 24'hA5A5A5, 24'h0000FF};
    set_frame(3, 3);
    for (int i = 0; i < 9; i++) send_pixel(px[i]);
  endtask

  // 4x4 ramp: border pass-through and four interior means
  task automatic test_border_passthrough();
    set_frame(4, 4);
    for (int k = 0; k < 16; k++)
      send_pixel({8'(k * 37), 8'(255 - 17 * k), 8'(17 * k)});
  endtask

  task automatic test_random_frames(input int frames);
    int unsigned w;
    int unsigned h;
    for (int i = 0; i < frames; i++) begin
      w = $urandom_range(9, MIN_SIZE);
      h = $urandom_range(7, MIN_SIZE);
      set_frame(w, h);
      send_random_pixels(w * h);
    end
  endtask

  // result side held off long enough for the block to fill and stall its input
  task automatic test_result_backpressure();
    set_frame(7, 5);
    stall_request <= LONG_STALL;
    send_random_pixels(35);
  endtask

  // width shrinks below the column position mid-frame: raster moves to the next row
  task automatic test_width_change_mid_frame();
    set_frame(10, 6);
    send_random_pixels(27);
    settle();
    write_size(REG_IMAGE_WIDTH, 5);
    send_random_pixels(15);
  endtask

  // tallest setting, then height cut below the current row: frame restarts
  task automatic test_tallest_frame();
    set_frame(3, MAX_HEIGHT);
    send_random_pixels(60);
    settle();
    write_size(REG_IMAGE_HEIGHT, 4);
    send_random_pixels(12);
  endtask

  initial begin
    rst_n           <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    pix_ch.valid    <= 1'b0;
    pix_ch.red_in   <= '0;
    pix_ch.green_in <= '0;
    pix_ch.blue_in  <= '0;
    raster_col = 0;
    raster_row = 0;
    img_width  = WIDTH_RESET;
    img_height = HEIGHT_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(23, 77);
    test_size_registers();
    test_corner_mean();
    test_border_passthrough();
    test_random_frames(1);
    test_result_backpressure();

    set_idling(77, 23);
    test_random_frames(1);
    test_width_change_mid_frame();

    set_idling(0, 0);
    test_random_frames(2);
    test_tallest_frame();

    settle();
    if (bad_count == 0 && expected_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/daif_pkg.sv
rtl/core/daif_if.sv
rtl/core/daif_cfg_regs.sv
rtl/core/daif_line_store.sv
rtl/core/diagonal_average_image_filter.sv
verif/tb_diagonal_average_image_filter.sv
